>>> hw/rtl/swa_pkg.sv
`timescale 1ns / 1ps

package swa_pkg;

    localparam int WINDOW_MAX  = 32;
    localparam int SAMPLE_BITS = 16;
    localparam int LEN_BITS    = 6;
    localparam int POS_BITS    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int SUM_BITS    = SAMPLE_BITS + POS_BITS;
    localparam int DIV_STEPS   = SUM_BITS;
    localparam int CNT_BITS    = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPDATE,
        S_START,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load_sample;
        logic do_update;
        logic div_start;
        logic div_step;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage

>>> hw/rtl/swa_ctrl.sv
`timescale 1ns / 1ps

module swa_ctrl
    import swa_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state              r_state;
    t_state              n_state;
    logic [CNT_BITS-1:0] r_cnt;
    logic [CNT_BITS-1:0] n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                n_state = S_START;
            end
            S_START: begin
                n_state = S_DIV;
                n_cnt   = '0;
            end
            S_DIV: begin
                if (r_cnt == CNT_BITS'(DIV_STEPS - 1)) begin
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready        = 1'b1;
                o_cmd.load_sample = i_in_valid;
            end
            S_UPDATE: begin
                o_cmd.do_update = 1'b1;
            end
            S_START: begin
                o_cmd.div_start = 1'b1;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            S_DONE: begin
                o_cmd.out_load = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

>>> hw/rtl/swa_datapath.sv
`timescale 1ns / 1ps

module swa_datapath
    import swa_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_window_length_we,
    input  logic [LEN_BITS-1:0]           i_window_length,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  t_dp_cmd                       i_cmd,
    output t_dp_status                    o_status,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [SAMPLE_BITS-1:0] o_average
);

    logic [SAMPLE_BITS-1:0] r_mem [WINDOW_MAX];
    logic [WINDOW_MAX-1:0]  r_entry_valid;

    logic [LEN_BITS-1:0]        r_len;
    logic [POS_BITS-1:0]        r_pos;
    logic [POS_BITS-1:0]        r_rd_pos;
    logic [SAMPLE_BITS-1:0]     r_sample;
    logic [SAMPLE_BITS-1:0]     r_rd_data;
    logic                       r_rd_valid;
    logic signed [SUM_BITS-1:0] r_sum;
    logic [SUM_BITS-1:0]        r_quo;
    logic [LEN_BITS-1:0]        r_rem;
    logic                       r_neg;
    logic                       r_out_valid;
    logic [SAMPLE_BITS-1:0]     r_avg;

    logic [LEN_BITS-1:0]    n_len;
    logic [POS_BITS-1:0]    eff_pos;
    logic [LEN_BITS:0]      pos_inc;
    logic [POS_BITS-1:0]    n_pos;
    logic [SAMPLE_BITS-1:0] old_val;
    logic [SUM_BITS-1:0]    sum_mag;
    logic [LEN_BITS:0]      trial;
    logic                   fits;
    logic [SUM_BITS-1:0]    quo_signed;

    always_comb begin
        n_len = i_window_length;
        if (i_window_length == '0) begin
            n_len = LEN_BITS'(1);
        end else if (i_window_length > LEN_BITS'(WINDOW_MAX)) begin
            n_len = LEN_BITS'(WINDOW_MAX);
        end
    end

    assign eff_pos = (LEN_BITS'(r_pos) >= r_len) ? '0 : r_pos;
    assign pos_inc = (LEN_BITS + 1)'(r_rd_pos) + 1'b1;
    assign n_pos   = (pos_inc >= {1'b0, r_len}) ? '0 : pos_inc[POS_BITS-1:0];
    assign old_val = r_rd_valid ? r_rd_data : '0;

    assign sum_mag    = r_sum[SUM_BITS-1] ? (~r_sum + 1'b1) : r_sum;
    assign trial      = {r_rem, r_quo[SUM_BITS-1]};
    assign fits       = trial >= {1'b0, r_len};
    assign quo_signed = r_neg ? (~r_quo + 1'b1) : r_quo;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_sample) begin
            r_rd_data <= r_mem[eff_pos];
        end
        if (i_cmd.do_update) begin
            r_mem[r_rd_pos] <= r_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len         <= LEN_BITS'(1);
            r_pos         <= '0;
            r_sum         <= '0;
            r_entry_valid <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_window_length_we) begin
                r_len         <= n_len;
                r_pos         <= '0;
                r_sum         <= '0;
                r_entry_valid <= '0;
            end
            if (i_cmd.do_update) begin
                r_sum <= r_sum
                       + {{POS_BITS{r_sample[SAMPLE_BITS-1]}}, r_sample}
                       - {{POS_BITS{old_val[SAMPLE_BITS-1]}}, old_val};
                r_entry_valid[r_rd_pos] <= 1'b1;
                r_pos <= n_pos;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_sample) begin
            r_sample   <= i_sample;
            r_rd_pos   <= eff_pos;
            r_rd_valid <= r_entry_valid[eff_pos];
        end
        if (i_cmd.div_start) begin
            r_quo <= sum_mag;
            r_rem <= '0;
            r_neg <= r_sum[SUM_BITS-1];
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[SUM_BITS-2:0], fits};
            r_rem <= fits ? LEN_BITS'(trial - {1'b0, r_len}) : trial[LEN_BITS-1:0];
        end
        if (i_cmd.out_load) begin
            r_avg <= quo_signed[SAMPLE_BITS-1:0];
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_average         = r_avg;

endmodule

>>> hw/rtl/sliding_window_average.sv
`timescale 1ns / 1ps

// Boxcar moving average of signed 16-bit samples over the last window_length
// samples (1 to 32; 0 reads as 1, larger values as 32). Writing the length
// clears the window, write position and sum, and zeros left by a clear count
// in the average until the window fills. Each average is the exact window sum
// divided by the length, truncated toward zero. One sample is in work at a
// time. The window entry is read at the transfer. After that, the update
// state updates the sum and the start state loads the divider. The restoring
// divider then runs, one quotient bit per cycle, and the done state loads the
// output register, after which a new sample can be taken. The next sample is
// taken while a result waits in the output register. A finished average
// holds in the divider until that register is free.

module sliding_window_average
    import swa_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_window_length_we,
    input  logic [LEN_BITS-1:0]           i_window_length,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [SAMPLE_BITS-1:0] o_average
);

    t_dp_cmd    cmd;
    t_dp_status status;

    swa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    swa_datapath u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_window_length_we (i_window_length_we),
        .i_window_length    (i_window_length),
        .i_sample           (i_sample),
        .i_cmd              (cmd),
        .o_status           (status),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_average          (o_average)
    );

endmodule

>>> tb/swa_average_checker.sv
`timescale 1ns / 1ps

module swa_average_checker
    import swa_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_window_length_we,
    input  logic [LEN_BITS-1:0]           i_window_length,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_average,
    output int                            o_errors,
    output int                            o_pending
);

    logic signed [SAMPLE_BITS-1:0] hist [WINDOW_MAX];
    logic signed [SAMPLE_BITS-1:0] avg_queue [$];
    logic signed [SAMPLE_BITS-1:0] want;
    int unsigned                   slot;
    int unsigned                   win_len;
    longint                        win_sum;
    longint                        quot;
    int                            err_count = 0;

    assign o_errors = err_count;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (hist[k]) hist[k] = '0;
            slot    = 0;
            win_sum = 0;
            win_len = 1;
            avg_queue.delete();
        end else begin
            if (i_window_length_we) begin
                win_len = 32'(i_window_length);
                if (win_len < 1) win_len = 1;
                if (win_len > WINDOW_MAX) win_len = WINDOW_MAX;
                foreach (hist[k]) hist[k] = '0;
                slot    = 0;
                win_sum = 0;
            end
            // check the result transfer before queuing a new expectation
            if (i_out_valid && i_out_ready) begin
                if (avg_queue.size() == 0) begin
                    $error("average: result with no expectation, actual %0d", i_average);
                    err_count++;
                end else begin
                    want = avg_queue.pop_front();
                    if (i_average !== want) begin
                        $error("average mismatch: expected %0d, actual %0d", want, i_average);
                        err_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (slot >= win_len) slot = 0;
                win_sum = win_sum + longint'(i_sample) - longint'(hist[slot]);
                hist[slot] = i_sample;
                slot++;
                if (slot >= win_len) slot = 0;
                quot = win_sum / longint'(win_len);
                avg_queue.push_back(quot[SAMPLE_BITS-1:0]);
            end
        end
        o_pending <= avg_queue.size();
    end

endmodule

>>> tb/tb_sliding_window_average.sv
`timescale 1ns / 1ps

module tb_sliding_window_average;
    import swa_pkg::*;

    localparam int TOTAL_SAMPLES = 1450;
    localparam int QUIET_TAIL    = 1300;
    localparam int SETTLE_CYCLES = 30;
    localparam int STALL_LIMIT   = 2000;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_window_length_we = 1'b0;
    logic [LEN_BITS-1:0]           i_window_length = '0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_ready;
    logic signed [SAMPLE_BITS-1:0] i_sample = '0;
    logic                          o_out_valid;
    logic                          i_out_ready = 1'b0;
    logic signed [SAMPLE_BITS-1:0] o_average;

    int errors;
    int pending;
    int quiet_cycles = 0;
    int stall_left = 0;
    bit jitter = 1'b1;
    int sent = 0;
    int length_writes = 0;

    sliding_window_average dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_window_length_we (i_window_length_we),
        .i_window_length    (i_window_length),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_sample           (i_sample),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_average          (o_average)
    );

    swa_average_checker checker_inst (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_window_length_we (i_window_length_we),
        .i_window_length    (i_window_length),
        .i_in_valid         (i_in_valid),
        .i_in_ready         (o_in_ready),
        .i_sample           (i_sample),
        .i_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .i_average          (o_average),
        .o_errors           (errors),
        .o_pending          (pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // stall the result side in random bursts
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= stall_left - 1;
        end else if (jitter && $urandom_range(0, 5) == 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= $urandom_range(0, 6);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_sliding_window_average: errors");
            $finish;
        end
    end

    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] value);
        i_in_valid <= 1'b1;
        i_sample   <= value;
        do @(posedge i_clk); while (!o_in_ready);
        sent++;
        if (jitter && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
    endtask

    // hold off until every average has come back, then let the block settle
    task automatic wait_for_averages();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_window_length(input logic [LEN_BITS-1:0] value);
        i_window_length_we <= 1'b1;
        i_window_length    <= value;
        @(posedge i_clk);
        i_window_length_we <= 1'b0;
        length_writes++;
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(input int mode);
        logic signed [SAMPLE_BITS-1:0] v;
        v = SAMPLE_BITS'($urandom);
        case (mode)
            1: if ($urandom_range(0, 3) != 0) v = 16'sh7fff;
            2: if ($urandom_range(0, 3) != 0) v = -16'sh8000;
            3: v = SAMPLE_BITS'($signed($urandom_range(0, 64)) - 32);
            default: begin
                case ($urandom_range(0, 9))
                    0: v = 16'sh7fff;
                    1: v = -16'sh8000;
                    2: v = SAMPLE_BITS'($signed($urandom_range(0, 8)) - 4);
                    default: ;
                endcase
            end
        endcase
        return v;
    endfunction

    initial begin
        int n;
        int mode;
        int phase_no;
        logic [LEN_BITS-1:0] len_val;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // length 1 from reset
        send_sample(16'sh7fff);
        send_sample(-16'sh8000);
        send_sample(16'sh0000);
        send_sample(-16'sh0001);
        send_sample(16'sh0001);
        wait_for_averages();
        // zero length reads as one
        set_window_length(6'd0);
        send_sample(16'sd12345);
        send_sample(-16'sd12345);
        wait_for_averages();
        set_window_length(6'd2);
        send_sample(16'sh7fff);
        send_sample(16'sh7fff);
        send_sample(-16'sh8000);
        send_sample(-16'sh8000);
        send_sample(-16'sh0001);
        wait_for_averages();
        // truncation toward zero on negative sums
        set_window_length(6'd3);
        send_sample(-16'sh0001);
        send_sample(-16'sh0001);
        send_sample(16'sh0000);
        send_sample(16'sd5);
        wait_for_averages();
        // oversized length saturates
        set_window_length(6'd63);
        send_sample(16'sh7fff);
        send_sample(-16'sh8000);
        send_sample(16'sd100);
        wait_for_averages();
        set_window_length(6'd32);
        send_sample(-16'sd7);
        send_sample(16'sh7fff);

        phase_no = 0;
        while (sent < TOTAL_SAMPLES) begin
            // no pauses and no length writes in the closing stretch
            if (sent < QUIET_TAIL) begin
                wait_for_averages();
                case (phase_no)
                    0: len_val = 6'd32;
                    1: len_val = 6'd1;
                    2: len_val = 6'd33;
                    3: len_val = 6'd0;
                    4: len_val = 6'd63;
                    default: begin
                        case ($urandom_range(0, 5))
                            0: len_val = 6'd32;
                            1: len_val = 6'd1;
                            default: len_val = LEN_BITS'($urandom_range(0, 63));
                        endcase
                    end
                endcase
                if (phase_no < 5 || $urandom_range(0, 3) != 0) set_window_length(len_val);
            end
            n    = $urandom_range(20, 140);
            mode = $urandom_range(0, 3);
            for (int i = 0; i < n && sent < TOTAL_SAMPLES; i++) begin
                jitter = (sent < QUIET_TAIL);
                send_sample(pick_sample(mode));
            end
            phase_no++;
        end

        wait_for_averages();
        $display("run covered %0d samples, %0d window length writes, stalls on both sides",
                 sent, length_writes);
        if (errors == 0) begin
            $display("tb_sliding_window_average: clean");
        end else begin
            $display("tb_sliding_window_average: errors");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/swa_pkg.sv
hw/rtl/swa_ctrl.sv
hw/rtl/swa_datapath.sv
hw/rtl/sliding_window_average.sv
tb/swa_average_checker.sv
tb/tb_sliding_window_average.sv
